// File: hdl/itfr_pkg.sv
// Package for the idle-timeout frame receiver: codes, control word layout,
// status bundle and the microcode program table.
// No dependencies.
`timescale 1ns / 1ps

package itfr_pkg;

  localparam int BUF_DEPTH_DEFAULT = 64;

  localparam int BYTE_W    = 8;
  localparam int IDLE_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd10;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;

  localparam logic [BYTE_W-1:0] HDR0 = 8'h55;
  localparam logic [BYTE_W-1:0] HDR1 = 8'hAA;
  localparam int LEN_POS   = 2;
  localparam int MIN_FRAME = LEN_POS + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_XOR_CHECK_ENABLE = 1'b1;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_FLAG = 1'b1;

  typedef logic [3:0] step_t;

  // Program addresses.
  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_RD_HDR0  = 4'd1;
  localparam step_t ST_RD_HDR1  = 4'd2;
  localparam step_t ST_RD_LEN   = 4'd3;
  localparam step_t ST_CHK_LEN  = 4'd4;
  localparam step_t ST_MODE     = 4'd5;
  localparam step_t ST_XOR_RD   = 4'd6;
  localparam step_t ST_XOR_ACC  = 4'd7;
  localparam step_t ST_XOR_CHK  = 4'd8;
  localparam step_t ST_FLAG     = 4'd9;
  localparam step_t ST_ECHO_RD  = 4'd10;
  localparam step_t ST_ECHO_OUT = 4'd11;
  localparam step_t ST_CLEAR    = 4'd12;

  typedef enum logic [1:0] {
    AD_ZERO,
    AD_ONE,
    AD_TWO,
    AD_IDX
  } addr_sel_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_TIMEOUT,
    C_SHORT,
    C_HDR0_BAD,
    C_HDR1_BAD,
    C_LEN_BAD,
    C_XOR_OFF,
    C_IDX_EQ_LEN,
    C_ACC_NZ
  } cond_t;

  typedef struct packed {
    logic      in_rdy;
    addr_sel_t addr_sel;
    cond_t     cond;
    logic      wait_out;
    logic      emit_byte;
    logic      emit_flag;
    logic      len_ld;
    logic      idx_clr;
    logic      idx_inc;
    logic      acc_clr;
    logic      acc_xor;
    logic      clr_frame;
    step_t     jt;
    step_t     jf;
  } cw_t;

  typedef struct packed {
    logic timeout;
    logic short_frame;
    logic hdr0_bad;
    logic hdr1_bad;
    logic len_bad;
    logic xor_off;
    logic idx_eq_len;
    logic acc_nz;
    logic out_free;
  } stat_t;

  // The program. Buffer reads are registered, so a word that tests a byte
  // sees the address issued by the word before it.
  function automatic cw_t ucode_rom(input step_t step);
    cw_t cw;
    cw = '0;
    cw.addr_sel = AD_IDX;
    cw.cond = C_NEVER;
    cw.jt = ST_IDLE;
    cw.jf = ST_IDLE;
    case (step)
      ST_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond = C_TIMEOUT;
        cw.jt = ST_RD_HDR0;
        cw.jf = ST_IDLE;
      end
      ST_RD_HDR0: begin
        cw.addr_sel = AD_ZERO;
        cw.cond = C_SHORT;
        cw.jt = ST_CLEAR;
        cw.jf = ST_RD_HDR1;
      end
      ST_RD_HDR1: begin
        cw.addr_sel = AD_ONE;
        cw.cond = C_HDR0_BAD;
        cw.jt = ST_CLEAR;
        cw.jf = ST_RD_LEN;
      end
      ST_RD_LEN: begin
        cw.addr_sel = AD_TWO;
        cw.cond = C_HDR1_BAD;
        cw.jt = ST_CLEAR;
        cw.jf = ST_CHK_LEN;
      end
      ST_CHK_LEN: begin
        cw.cond = C_LEN_BAD;
        cw.len_ld = 1'b1;
        cw.idx_clr = 1'b1;
        cw.acc_clr = 1'b1;
        cw.jt = ST_CLEAR;
        cw.jf = ST_MODE;
      end
      ST_MODE: begin
        cw.cond = C_XOR_OFF;
        cw.jt = ST_ECHO_RD;
        cw.jf = ST_XOR_RD;
      end
      ST_XOR_RD: begin
        cw.jf = ST_XOR_ACC;
      end
      ST_XOR_ACC: begin
        // On the length index the byte is folded in as well, so the sum
        // is zero exactly when it matched.
        cw.acc_xor = 1'b1;
        cw.idx_inc = 1'b1;
        cw.cond = C_IDX_EQ_LEN;
        cw.jt = ST_XOR_CHK;
        cw.jf = ST_XOR_RD;
      end
      ST_XOR_CHK: begin
        cw.cond = C_ACC_NZ;
        cw.jt = ST_CLEAR;
        cw.jf = ST_FLAG;
      end
      ST_FLAG: begin
        cw.wait_out = 1'b1;
        cw.emit_flag = 1'b1;
        cw.jf = ST_CLEAR;
      end
      ST_ECHO_RD: begin
        cw.jf = ST_ECHO_OUT;
      end
      ST_ECHO_OUT: begin
        cw.wait_out = 1'b1;
        cw.emit_byte = 1'b1;
        cw.idx_inc = 1'b1;
        cw.cond = C_IDX_EQ_LEN;
        cw.jt = ST_CLEAR;
        cw.jf = ST_ECHO_RD;
      end
      ST_CLEAR: begin
        cw.clr_frame = 1'b1;
      end
      default: begin
        cw.jf = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: hdl/itfr_if.sv
// Request channel interfaces of the frame receiver: input items and results.
// Depends on itfr_pkg.
`timescale 1ns / 1ps

interface itfr_in_if import itfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;

  modport source(output valid, output op, output rx_byte, input ready);
  modport sink(input valid, input op, input rx_byte, output ready);
endinterface

interface itfr_out_if import itfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              kind;

  modport source(output valid, output out_byte, output last, output kind, input ready);
  modport sink(input valid, input out_byte, input last, input kind, output ready);
endinterface

// File: hdl/itfr_seq.sv
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on itfr_pkg.
`timescale 1ns / 1ps

module itfr_seq import itfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cw_t   cw,
  output logic  go
);

  step_t step;
  step_t step_next;
  logic  cond_hit;

  assign cw = ucode_rom(step);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_TIMEOUT:    cond_hit = stat.timeout;
      C_SHORT:      cond_hit = stat.short_frame;
      C_HDR0_BAD:   cond_hit = stat.hdr0_bad;
      C_HDR1_BAD:   cond_hit = stat.hdr1_bad;
      C_LEN_BAD:    cond_hit = stat.len_bad;
      C_XOR_OFF:    cond_hit = stat.xor_off;
      C_IDX_EQ_LEN: cond_hit = stat.idx_eq_len;
      C_ACC_NZ:     cond_hit = stat.acc_nz;
      default:      cond_hit = 1'b0;
    endcase
  end

  // A word that emits a result holds until the output register can take it.
  always_comb begin
    go = !(cw.wait_out && !stat.out_free);
    if (!go) begin
      step_next = step;
    end else if (cond_hit) begin
      step_next = cw.jt;
    end else begin
      step_next = cw.jf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: hdl/itfr_dp.sv
// Datapath of the frame receiver: frame buffer memory, byte and idle
// counters, configuration registers, check unit and output register.
// Depends on itfr_pkg and itfr_if; driven by control words from itfr_seq.
`timescale 1ns / 1ps

module itfr_dp import itfr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cw_t                   cw,
  input  logic                  go,
  output stat_t                 stat,
  itfr_in_if.sink               rx_chan,
  itfr_out_if.source            tx_chan
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     byte_count;
  logic [IDLE_W-1:0] idle_ticks;
  logic [IDLE_W-1:0] idle_inc;
  logic [IDLE_W-1:0] timeout_limit;
  logic              xor_check_enable;

  logic [AW-1:0]     idx;
  logic [AW-1:0]     len;
  logic [BYTE_W-1:0] acc;
  logic [8:0]        len_p1;

  logic              rx_accept;
  logic              store;
  logic              tick;
  logic              load;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_kind;

  assign rx_chan.ready = cw.in_rdy;
  assign rx_accept = rx_chan.valid && rx_chan.ready;
  assign store = rx_accept && (rx_chan.op == OP_BYTE) && (byte_count < CW'(BUF_DEPTH));
  assign tick = rx_accept && (rx_chan.op == OP_TICK);
  assign idle_inc = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;

  always_comb begin
    unique case (cw.addr_sel)
      AD_ZERO: raddr = '0;
      AD_ONE:  raddr = AW'(1);
      AD_TWO:  raddr = AW'(LEN_POS);
      AD_IDX:  raddr = idx;
      default: raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[byte_count[AW-1:0]] <= rx_chan.rx_byte;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
      xor_check_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT_LIMIT:    timeout_limit <= cfg_data;
        REG_XOR_CHECK_ENABLE: xor_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      idle_ticks <= '0;
    end else if (go && cw.clr_frame) begin
      byte_count <= '0;
      idle_ticks <= '0;
    end else if (store) begin
      // The first byte of a frame restarts the idle count.
      if (byte_count == '0) begin
        idle_ticks <= '0;
      end
      byte_count <= byte_count + CW'(1);
    end else if (tick) begin
      idle_ticks <= idle_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (cw.len_ld) begin
        len <= rdata[AW-1:0];
      end
      if (cw.idx_clr) begin
        idx <= '0;
      end else if (cw.idx_inc) begin
        idx <= idx + AW'(1);
      end
      if (cw.acc_clr) begin
        acc <= '0;
      end else if (cw.acc_xor) begin
        acc <= acc ^ rdata;
      end
    end
  end

  assign len_p1 = 9'(rdata) + 9'd1;

  always_comb begin
    stat.timeout     = tick && (idle_inc > timeout_limit);
    stat.short_frame = byte_count < CW'(MIN_FRAME);
    stat.hdr0_bad    = rdata != HDR0;
    stat.hdr1_bad    = rdata != HDR1;
    stat.len_bad     = len_p1 != 9'(byte_count);
    stat.xor_off     = !xor_check_enable;
    stat.idx_eq_len  = idx == len;
    stat.acc_nz      = acc != '0;
    stat.out_free    = !out_valid || tx_chan.ready;
  end

  assign load = go && (cw.emit_byte || cw.emit_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tx_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cw.emit_flag) begin
        out_byte <= '0;
        out_last <= 1'b1;
        out_kind <= KIND_FLAG;
      end else begin
        out_byte <= rdata;
        out_last <= idx == len;
        out_kind <= KIND_ECHO;
      end
    end
  end

  assign tx_chan.valid    = out_valid;
  assign tx_chan.out_byte = out_byte;
  assign tx_chan.last     = out_last;
  assign tx_chan.kind     = out_kind;

endmodule

// File: hdl/idle_timeout_frame_receiver.sv
// Top level of the idle-timeout frame receiver: sequencer plus datapath.
// Depends on itfr_pkg, itfr_if, itfr_seq and itfr_dp.
`timescale 1ns / 1ps

// Each request is either a received byte or a timer tick. A byte is stored
// in the buffer; a tick that does not exceed the timeout bumps the idle count.
// A tick past the timeout starts the frame check, run by a microcoded
// sequencer over one registered read port of the frame buffer: header and
// length steps, then either a read and a fold step per byte through the
// length index plus the XOR check and flag steps, or a read and an output
// step per echoed byte, and a clear step for the frame; results wait on
// the output register when the sink stalls. A frame that fails on its
// header or length ends at the clear step; one that fails the XOR check
// ends after the check and the clear. No request is taken while a check
// runs. The buffer holds BUF_DEPTH bytes; later bytes of a frame are dropped.
module idle_timeout_frame_receiver import itfr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  itfr_in_if.sink               rx_chan,
  itfr_out_if.source            tx_chan
);

  cw_t   cw;
  stat_t stat;
  logic  go;

  itfr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw),
    .go   (go)
  );

  itfr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cw        (cw),
    .go        (go),
    .stat      (stat),
    .rx_chan   (rx_chan),
    .tx_chan   (tx_chan)
  );

endmodule

// File: hdl/itfr_checker.sv
// Port-level assertions for the frame receiver and the bind that attaches
// them to the top level. Depends on itfr_pkg and idle_timeout_frame_receiver.
`timescale 1ns / 1ps

module itfr_checker import itfr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last,
  input logic              out_kind
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

  // Results are only loaded while a check runs and requests are blocked.
  a_load_in_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared outside a frame check");

  // An accept flag, the only result of its frame, is marked last with a zero byte.
  a_flag_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_FLAG |-> out_last && out_byte == '0)
    else $error("malformed accept flag");

  // A stored byte never starts a check.
  a_byte_no_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op == OP_BYTE |=> in_ready)
    else $error("byte request blocked the input");

endmodule

bind idle_timeout_frame_receiver itfr_checker u_itfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rx_chan.valid),
  .in_ready  (rx_chan.ready),
  .in_op     (rx_chan.op),
  .out_valid (tx_chan.valid),
  .out_ready (tx_chan.ready),
  .out_byte  (tx_chan.out_byte),
  .out_last  (tx_chan.last),
  .out_kind  (tx_chan.kind)
);
